// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL of the state path encoder.
// Each macro expects signals named clk and arst_n in the using module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/a2rsp_pkg.sv -----
// ---------------------------------------------------------------------------
// a2rsp_pkg
// Types and codes of the alignment to run-length state path encoder.
// ---------------------------------------------------------------------------
package a2rsp_pkg;

	localparam int COL_W       = 17;
	localparam int LEN_W       = 17;
	localparam int MAX_RESULTS = 4;
	localparam int CNT_W       = 3;

	localparam logic [COL_W-1:0] MAX_COLUMNS = COL_W'(65536);
	localparam logic [LEN_W-1:0] RUN_MAX     = '1;

	// request kinds
	localparam logic REQ_SCAN = 1'b0;
	localparam logic REQ_EMIT = 1'b1;

	// result kinds
	localparam logic [1:0] RES_RUN     = 2'd0;
	localparam logic [1:0] RES_SCAN_OK = 2'd1;
	localparam logic [1:0] RES_NO_CONS = 2'd2;

	// profile state codes
	localparam logic [3:0] ST_N  = 4'd0;
	localparam logic [3:0] ST_L  = 4'd1;
	localparam logic [3:0] ST_G  = 4'd2;
	localparam logic [3:0] ST_ML = 4'd3;
	localparam logic [3:0] ST_MG = 4'd4;
	localparam logic [3:0] ST_IL = 4'd5;
	localparam logic [3:0] ST_IG = 4'd6;
	localparam logic [3:0] ST_DL = 4'd7;
	localparam logic [3:0] ST_DG = 4'd8;
	localparam logic [3:0] ST_C  = 4'd9;

	typedef struct packed {
		logic req_type;
		logic is_consensus;
		logic is_gap;
		logic first_column;
		logic last_column;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       result_type;
		logic [3:0]       state_code;
		logic [LEN_W-1:0] run_length;
		logic             last_run;
	} out_item_t;

	// persistent scan and path state
	typedef struct packed {
		logic [COL_W-1:0] column_index;
		logic [COL_W-1:0] first_cons_col;
		logic [COL_W-1:0] last_cons_col;
		logic [COL_W-1:0] last_res_col;
		logic             seen_consensus;
		logic             entered_homology;
		logic [3:0]       open_state;
		logic [LEN_W-1:0] open_len;
		logic             run_open;
	} ctx_t;

	// outcome of one column
	typedef struct packed {
		ctx_t                             ctx;
		logic [CNT_W-1:0]                 cnt;
		out_item_t [MAX_RESULTS-1:0]      res;
	} step_t;

endpackage

// ----- hdl/alignment_to_rle_state_path_top.sv -----
// ---------------------------------------------------------------------------
// alignment_to_rle_state_path_top
// Scans alignment columns for consensus boundaries, then emits the
// run-length encoded local or glocal profile state path.
//
//   channel | direction | payload                 | handshake
//   in      | input     | in_item  (in_item_t)    | in_valid / in_ready
//   out     | output    | out_item (out_item_t)   | out_valid / out_ready
//   cfg     | input     | cfg_data (glocal_mode)  | cfg_valid / cfg_ready
//
// Each column is held in the input register, then its 0 to 4 results
// load the result buffer, which sends one item per cycle while out_ready is high.
// A new column is taken every cycle while the buffer can be refilled; else
// a column waits in the input register until the buffer is empty or its last
// result is taken. A column passes the input register, then the result buffer.
// Reset clears all scan and path state and selects local mode; the config
// port is always ready.
// ---------------------------------------------------------------------------
module alignment_to_rle_state_path_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  a2rsp_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output a2rsp_pkg::out_item_t out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data
);

`include "assert_macros.svh"

	logic                                          glocal_q;
	a2rsp_pkg::ctx_t                               ctx_q;
	logic                                          valid_s1;
	a2rsp_pkg::in_item_t                           item_s1;
	logic [a2rsp_pkg::CNT_W-1:0]                   cnt_s2;
	a2rsp_pkg::out_item_t [a2rsp_pkg::MAX_RESULTS-1:0] res_s2;
	a2rsp_pkg::step_t                              step;
	logic                                          s2_free;
	logic                                          fire_s1;
	logic                                          out_fire;

	// config register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glocal_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			glocal_q <= cfg_data;
		end
	end

	// handshake control
	assign out_valid = (cnt_s2 != '0);
	assign out_fire  = out_valid && out_ready;
	assign s2_free   = (cnt_s2 == '0) || (cnt_s2 == a2rsp_pkg::CNT_W'(1) && out_ready);
	assign fire_s1   = valid_s1 && s2_free;
	assign in_ready  = !valid_s1 || fire_s1;
	assign out_item  = res_s2[0];

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_s1 <= in_item;
	end

	a2rsp_step u_step (
		.item   (item_s1),
		.glocal (glocal_q),
		.ctx    (ctx_q),
		.step   (step)
	);

	// context and result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q  <= '0;
			cnt_s2 <= '0;
		end else begin
			if (fire_s1) begin
				ctx_q  <= step.ctx;
				cnt_s2 <= step.cnt;
			end else if (out_fire) begin
				cnt_s2 <= cnt_s2 - 1'b1;
			end
		end
	end

	// result buffer, head at entry 0
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= step.res;
		end else if (out_fire) begin
			for (int k = 0; k < a2rsp_pkg::MAX_RESULTS - 1; k++) begin
				res_s2[k] <= res_s2[k+1];
			end
		end
	end

	`ASSERT_NOW(a_cnt_range, 1'b1, cnt_s2 <= a2rsp_pkg::CNT_W'(a2rsp_pkg::MAX_RESULTS), "result count above four")
	`ASSERT_NOW(a_open_len, ctx_q.run_open, ctx_q.open_len != '0, "open run has zero length")
	`ASSERT_NOW(a_col_sat, 1'b1, ctx_q.column_index <= a2rsp_pkg::MAX_COLUMNS, "column index past limit")
	`ASSERT_NEXT(a_load_shows, fire_s1 && step.cnt != '0, out_valid, "loaded results not shown")
	`ASSERT_NOW(a_scan_clean, out_valid && out_item.result_type != a2rsp_pkg::RES_RUN, out_item.state_code == a2rsp_pkg::ST_N && out_item.run_length == '0 && !out_item.last_run, "scan result carries run fields")

endmodule

// ----- hdl/a2rsp_step.sv -----
// ---------------------------------------------------------------------------
// a2rsp_step
// Maps one alignment column to its state additions, merges them into runs
// and returns the next context with up to four closed results.
// ---------------------------------------------------------------------------
module a2rsp_step (
	input  a2rsp_pkg::in_item_t item,
	input  logic                glocal,
	input  a2rsp_pkg::ctx_t     ctx,
	output a2rsp_pkg::step_t    step
);

	always_comb begin
		a2rsp_pkg::ctx_t                             c;
		a2rsp_pkg::out_item_t [a2rsp_pkg::MAX_RESULTS-1:0] r;
		logic [a2rsp_pkg::CNT_W-1:0]                 n;
		logic [a2rsp_pkg::COL_W-1:0]                 base;
		logic [a2rsp_pkg::COL_W-1:0]                 i;
		logic [a2rsp_pkg::COL_W-1:0]                 rcol;
		logic [3:0]                                  add_en;
		logic [3:0]                                  add_st [4];

		c      = ctx;
		r      = '0;
		n      = '0;
		add_en = '0;
		for (int k = 0; k < 4; k++) begin
			add_st[k] = a2rsp_pkg::ST_N;
		end

		// column count, restarted by the first column, saturating
		base = item.first_column ? '0 : ctx.column_index;
		i    = (base < a2rsp_pkg::MAX_COLUMNS) ? base + 1'b1 : base;
		rcol = (ctx.last_res_col > ctx.first_cons_col) ? ctx.last_res_col
			: ctx.first_cons_col;

		if (item.req_type == a2rsp_pkg::REQ_SCAN) begin
			// scan pass: track consensus boundaries
			if (item.first_column) begin
				c.first_cons_col = '0;
				c.last_cons_col  = '0;
				c.last_res_col   = '0;
				c.seen_consensus = 1'b0;
			end
			c.column_index = i;
			if (item.is_consensus) begin
				if (!c.seen_consensus) begin
					c.first_cons_col = i;
					c.seen_consensus = 1'b1;
				end
				c.last_cons_col = i;
				if (!item.is_gap) c.last_res_col = i;
			end
			if (item.last_column) begin
				r[0].result_type = c.seen_consensus ? a2rsp_pkg::RES_SCAN_OK
					: a2rsp_pkg::RES_NO_CONS;
				n = a2rsp_pkg::CNT_W'(1);
			end
		end else if (ctx.seen_consensus) begin
			// emit pass: path restart
			if (item.first_column) begin
				c.entered_homology = 1'b0;
				c.run_open         = 1'b0;
				c.open_len         = '0;
				add_en[0]          = 1'b1;
			end
			c.column_index = i;
			add_st[1] = glocal ? a2rsp_pkg::ST_G : a2rsp_pkg::ST_L;
			add_en[1] = (i == ctx.first_cons_col);

			// state of the column itself, then the trailing C
			if (glocal) begin
				if (item.is_consensus) begin
					add_en[2] = 1'b1;
					add_st[2] = item.is_gap ? a2rsp_pkg::ST_DG : a2rsp_pkg::ST_MG;
				end else if (!item.is_gap) begin
					add_en[2] = 1'b1;
					if (i > ctx.last_cons_col)       add_st[2] = a2rsp_pkg::ST_C;
					else if (i > ctx.first_cons_col) add_st[2] = a2rsp_pkg::ST_IG;
					else                             add_st[2] = a2rsp_pkg::ST_N;
				end
				add_en[3] = (i == ctx.last_cons_col);
			end else begin
				if (item.is_consensus) begin
					if (item.is_gap) begin
						if (!c.entered_homology) begin
							add_en[2] = 1'b1;
							add_st[2] = a2rsp_pkg::ST_L;
						end else if (i <= rcol) begin
							add_en[2] = 1'b1;
							add_st[2] = a2rsp_pkg::ST_DL;
						end
					end else begin
						c.entered_homology = 1'b1;
						add_en[2] = 1'b1;
						add_st[2] = a2rsp_pkg::ST_ML;
					end
				end else if (!item.is_gap) begin
					add_en[2] = 1'b1;
					if (i > rcol) begin
						c.entered_homology = 1'b1;
						add_st[2] = a2rsp_pkg::ST_C;
					end else if (c.entered_homology && i > ctx.first_cons_col) begin
						add_st[2] = a2rsp_pkg::ST_IL;
					end else begin
						add_st[2] = a2rsp_pkg::ST_N;
					end
				end
				add_en[3] = item.last_column;
			end
			add_st[3] = a2rsp_pkg::ST_C;

			// merge additions into runs, closing runs on a state change
			for (int k = 0; k < 4; k++) begin
				if (add_en[k]) begin
					if (c.run_open && add_st[k] == c.open_state) begin
						if (c.open_len != a2rsp_pkg::RUN_MAX) c.open_len = c.open_len + 1'b1;
					end else begin
						if (c.run_open && n < a2rsp_pkg::CNT_W'(a2rsp_pkg::MAX_RESULTS)) begin
							r[n[1:0]].result_type = a2rsp_pkg::RES_RUN;
							r[n[1:0]].state_code  = c.open_state;
							r[n[1:0]].run_length  = c.open_len;
							r[n[1:0]].last_run    = 1'b0;
							n = n + 1'b1;
						end
						c.open_state = add_st[k];
						c.open_len   = a2rsp_pkg::LEN_W'(1);
						c.run_open   = 1'b1;
					end
				end
			end

			// final column closes the path
			if (item.last_column) begin
				if (c.run_open && n < a2rsp_pkg::CNT_W'(a2rsp_pkg::MAX_RESULTS)) begin
					r[n[1:0]].result_type = a2rsp_pkg::RES_RUN;
					r[n[1:0]].state_code  = c.open_state;
					r[n[1:0]].run_length  = c.open_len;
					r[n[1:0]].last_run    = 1'b1;
					n = n + 1'b1;
				end
				c.run_open = 1'b0;
				c.open_len = '0;
			end
		end

		step.ctx = c;
		step.cnt = n;
		step.res = r;
	end

endmodule
